/* rtl/mkd_pkg.sv */
// shared types and constants of the matrix keypad debouncer
package mkd_pkg;

    // default matrix geometry
    localparam int NUM_COLUMNS_DEF = 3;
    localparam int NUM_ROWS_DEF    = 4;

    // field widths
    localparam int TICKS_W     = 8;
    localparam int FUNC_W      = 2;
    localparam int COLUMN_W    = 2;
    localparam int ROWS_W      = 4;
    localparam int KEY_W       = 4;
    localparam int LEVELS_W    = 12;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    // widths wide enough for the largest matrix (8 by 8)
    localparam int COL_IDX_W = 3;
    localparam int KEY_IDX_W = 6;

    localparam logic [TICKS_W-1:0] TICKS_RESET = 8'd100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SAMPLE       = 2'd0,
        FUNC_TAKE_PRESS   = 2'd1,
        FUNC_TAKE_RELEASE = 2'd2,
        FUNC_RESET_ALL    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        EDGE_IDLE    = 2'd0,
        EDGE_PRESS   = 2'd1,
        EDGE_RELEASE = 2'd2
    } t_edge;

    // per-key command decoded from one request
    typedef struct packed {
        logic sample;
        logic level;
        logic take_press;
        logic take_release;
        logic clear_all;
    } t_key_cmd;

endpackage

/* rtl/mkd_key_cell.sv */
// state and update logic of one key: raw sample, countdown, level, pending edge
module mkd_key_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  mkd_pkg::t_key_cmd             i_cmd,
    input  logic [mkd_pkg::TICKS_W-1:0]   i_ticks,
    output logic                          o_level_next,
    output logic                          o_taken
);

    logic                        r_last;
    logic                        n_last;
    logic [mkd_pkg::TICKS_W-1:0] r_count;
    logic [mkd_pkg::TICKS_W-1:0] n_count;
    logic                        r_level;
    logic                        n_level;
    mkd_pkg::t_edge              r_pending;
    mkd_pkg::t_edge              n_pending;
    logic [mkd_pkg::TICKS_W-1:0] w_dec;
    logic                        w_taken;

    // countdown saturates at zero
    assign w_dec = (r_count != '0) ? (r_count - mkd_pkg::TICKS_W'(1)) : '0;

    always_comb begin
        n_last    = r_last;
        n_count   = r_count;
        n_level   = r_level;
        n_pending = r_pending;
        w_taken   = 1'b0;
        if (i_en) begin
            if (i_cmd.clear_all) begin
                // countdown is left as it is
                n_last    = 1'b0;
                n_level   = 1'b0;
                n_pending = mkd_pkg::EDGE_IDLE;
            end else if (i_cmd.sample) begin
                if (i_cmd.level != r_last) begin
                    n_count = i_ticks;
                    n_last  = i_cmd.level;
                end else begin
                    n_count = w_dec;
                    if (w_dec == '0) begin
                        if (i_cmd.level && !r_level) begin
                            n_pending = mkd_pkg::EDGE_PRESS;
                        end else if (!i_cmd.level && r_level) begin
                            n_pending = mkd_pkg::EDGE_RELEASE;
                        end
                        n_level = i_cmd.level;
                    end
                end
            end else if (i_cmd.take_press && (r_pending == mkd_pkg::EDGE_PRESS)) begin
                n_pending = mkd_pkg::EDGE_IDLE;
                w_taken   = 1'b1;
            end else if (i_cmd.take_release && (r_pending == mkd_pkg::EDGE_RELEASE)) begin
                n_pending = mkd_pkg::EDGE_IDLE;
                w_taken   = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= 1'b0;
            r_count   <= '0;
            r_level   <= 1'b0;
            r_pending <= mkd_pkg::EDGE_IDLE;
        end else begin
            r_last    <= n_last;
            r_count   <= n_count;
            r_level   <= n_level;
            r_pending <= n_pending;
        end
    end

    assign o_level_next = n_level;
    assign o_taken      = w_taken;

endmodule

/* rtl/matrix_keypad_debouncer.sv */
// matrix keypad debouncer top level: request register, key cells, result register
// an accepted request is held in the request register, then its result in the result register
// throughput: one request per cycle while results are not stalled
// a stalled result holds in the result register while the request register takes one more
// reset (synchronous, active low) releases all keys, zeroes countdowns, reload value 100
// the configuration channel is always ready; write it only while the block is idle
module matrix_keypad_debouncer #(
    parameter int NUM_COLUMNS = mkd_pkg::NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = mkd_pkg::NUM_ROWS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write: debounce reload value
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [mkd_pkg::TICKS_W-1:0]       i_cfg_data,
    // request stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [mkd_pkg::IN_TDATA_W-1:0]    s_axis_tdata,  // column[1:0], rows_low[5:2], key[9:6]
    input  logic [mkd_pkg::FUNC_W-1:0]        s_axis_tuser,  // func[1:0]
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [mkd_pkg::OUT_TDATA_W-1:0]   m_axis_tdata   // key_levels[11:0], edge_taken[12]
);

    localparam int NUM_KEYS  = NUM_COLUMNS * NUM_ROWS;
    // keys that show up in the level field
    localparam int SHOWN     = (NUM_KEYS < mkd_pkg::LEVELS_W) ? NUM_KEYS : mkd_pkg::LEVELS_W;

    // debounce reload value
    logic [mkd_pkg::TICKS_W-1:0]  r_ticks;

    // request register
    logic                         r_in_valid;
    logic                         n_in_valid;
    mkd_pkg::t_func               r_func;
    logic [mkd_pkg::COLUMN_W-1:0] r_column;
    logic [mkd_pkg::ROWS_W-1:0]   r_rows;
    logic [mkd_pkg::KEY_W-1:0]    r_key;

    // result register
    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [mkd_pkg::LEVELS_W-1:0] r_levels;
    logic                         r_taken;

    logic                         w_out_ready;
    logic                         w_fire;
    logic                         w_in_accept;
    logic [NUM_KEYS-1:0]          w_level_next;
    logic [NUM_KEYS-1:0]          w_key_taken;
    logic [mkd_pkg::LEVELS_W-1:0] w_levels;

    // the request register advances whenever the result register can take a result
    assign w_out_ready   = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_out_ready;
    assign s_axis_tready = !r_in_valid || w_out_ready;
    assign w_in_accept   = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= mkd_pkg::TICKS_RESET;
        end else if (i_cfg_valid) begin
            r_ticks <= i_cfg_data;
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // request payload, unpacked on the way in
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_func   <= mkd_pkg::t_func'(s_axis_tuser);
            r_column <= s_axis_tdata[1:0];
            r_rows   <= s_axis_tdata[5:2];
            r_key    <= s_axis_tdata[9:6];
        end
    end

    // one cell per key; key index is column plus columns times row
    for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
        localparam int COL_IDX = k % NUM_COLUMNS;
        localparam int ROW_IDX = k / NUM_COLUMNS;

        mkd_pkg::t_key_cmd w_cmd;
        logic              w_col_hit;
        logic              w_key_hit;

        // a column beyond the matrix never matches, so that sample is dropped
        assign w_col_hit = ({1'b0, r_column} == mkd_pkg::COL_IDX_W'(COL_IDX));
        assign w_key_hit = ({2'b00, r_key} == mkd_pkg::KEY_IDX_W'(k));

        assign w_cmd.sample       = (r_func == mkd_pkg::FUNC_SAMPLE) && w_col_hit;
        assign w_cmd.take_press   = (r_func == mkd_pkg::FUNC_TAKE_PRESS) && w_key_hit;
        assign w_cmd.take_release = (r_func == mkd_pkg::FUNC_TAKE_RELEASE) && w_key_hit;
        assign w_cmd.clear_all    = (r_func == mkd_pkg::FUNC_RESET_ALL);

        // rows past the sampled field always read released
        if (ROW_IDX < mkd_pkg::ROWS_W) begin : g_row
            assign w_cmd.level = r_rows[ROW_IDX];
        end else begin : g_no_row
            assign w_cmd.level = 1'b0;
        end

        mkd_key_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_en         (w_fire),
            .i_cmd        (w_cmd),
            .i_ticks      (r_ticks),
            .o_level_next (w_level_next[k]),
            .o_taken      (w_key_taken[k])
        );
    end

    // level field: keys past twelve are not shown, missing keys read released
    for (genvar b = 0; b < mkd_pkg::LEVELS_W; b++) begin : g_lvl
        if (b < SHOWN) begin : g_on
            assign w_levels[b] = w_level_next[b];
        end else begin : g_off
            assign w_levels[b] = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_levels <= w_levels;
            r_taken  <= |w_key_taken;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_taken, r_levels};

endmodule

/* rtl/mkd_checker.sv */
// port-level checks of the matrix keypad debouncer, bound to the top level
module mkd_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [mkd_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // a stalled result keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // no result leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // requests back up only when a result is held by the downstream side
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("request side stalled without downstream stall");

    // an accepted request is followed by a valid result once it has passed the request and result registers
    a_req_to_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> ##2 m_axis_tvalid)
        else $error("accepted request produced no result");

    // the configuration channel never stalls out of reset
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write stalled");

endmodule

bind matrix_keypad_debouncer mkd_checker u_mkd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_cfg_valid   (i_cfg_valid),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
